/* src/chl_pkg.sv */
// ----------------------------------------------------------------------------
// chl_pkg
// Shared types and constants for the compacting handle list.
// ----------------------------------------------------------------------------
package chl_pkg;

    // Fixed field widths of the item ports
    localparam int KIND_W   = 2;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Defaults for the top level parameters
    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_HANDLE_BITS = 16;

    // Codes of the kind field
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_FULL_EMPTY = 2'd1,
        ST_NOT_FOUND  = 2'd2
    } t_status;

    // Classified command handed from the front to the back
    typedef struct packed {
        t_op                 op;
        logic [HANDLE_W-1:0] handle;
    } t_cmd;

endpackage

/* src/chl_ram.sv */
// ----------------------------------------------------------------------------
// chl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module chl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/chl_front.sv */
// ----------------------------------------------------------------------------
// chl_front
// Accepts items, decodes the kind into a command and queues it (two deep).
// ----------------------------------------------------------------------------
module chl_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [chl_pkg::KIND_W-1:0]   i_kind,
    input  logic [chl_pkg::HANDLE_W-1:0] i_handle,
    output logic                         o_cmd_valid,
    output chl_pkg::t_cmd                o_cmd,
    input  logic                         i_cmd_pop
);

    localparam logic [1:0] FILL_FULL = 2'd2;

    chl_pkg::t_cmd r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_fill;
    chl_pkg::t_cmd cmd_in;
    logic          push;

    // Kind three has its high bit set and acts as a clear
    always_comb begin
        cmd_in.handle = i_handle;
        case (i_kind)
            chl_pkg::KIND_INSERT: cmd_in.op = chl_pkg::OP_INSERT;
            chl_pkg::KIND_REMOVE: cmd_in.op = chl_pkg::OP_REMOVE;
            default:              cmd_in.op = chl_pkg::OP_CLEAR;
        endcase
    end

    assign o_in_ready  = (r_fill != FILL_FULL);
    assign push        = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, i_cmd_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

/* src/chl_back.sv */
// ----------------------------------------------------------------------------
// chl_back
// Executes queued commands against the slot RAM and registers the result.
// A remove scans the list once: entries after the first match are written
// one place down as they stream out of the RAM.
// ----------------------------------------------------------------------------
module chl_back #(
    parameter int CAPACITY    = chl_pkg::DEF_CAPACITY,
    parameter int HANDLE_BITS = chl_pkg::DEF_HANDLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  chl_pkg::t_cmd                i_cmd,
    output logic                         o_cmd_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [chl_pkg::STATUS_W-1:0] o_status,
    output logic [chl_pkg::COUNT_W-1:0]  o_entry_count,
    output logic                         o_is_empty,
    output logic                         o_is_full
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [AW-1:0]            r_tag, n_tag;
    logic                     r_found, n_found;
    logic [HANDLE_BITS-1:0]   r_key, n_key;
    logic                     r_out_valid, n_out_valid;
    chl_pkg::t_status         r_out_status, n_out_status;
    logic [CW-1:0]            r_out_count, n_out_count;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [HANDLE_BITS-1:0]   wr_data;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [HANDLE_BITS-1:0]   rd_data;
    logic                     last;
    logic                     match;
    logic                     result;

    chl_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (CAPACITY)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Take a command only when the result register is free
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid && !r_out_valid;
    assign last      = (CW'(r_tag) == (r_count - CW'(1)));
    assign match     = (rd_data == r_key);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_tag        = r_tag;
        n_found      = r_found;
        n_key        = r_key;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        result       = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_count[AW-1:0];
        wr_data      = HANDLE_BITS'(i_cmd.handle);
        rd_en        = 1'b0;
        rd_addr      = '0;

        case (r_state)
            S_IDLE: begin
                if (o_cmd_pop) begin
                    case (i_cmd.op)
                        chl_pkg::OP_INSERT: begin
                            result = 1'b1;
                            if (r_count >= CAP_COUNT) begin
                                n_out_status = chl_pkg::ST_FULL_EMPTY;
                            end else begin
                                wr_en        = 1'b1;
                                n_count      = r_count + CW'(1);
                                n_out_status = chl_pkg::ST_OK;
                            end
                        end
                        chl_pkg::OP_REMOVE: begin
                            if (r_count == '0) begin
                                result       = 1'b1;
                                n_out_status = chl_pkg::ST_FULL_EMPTY;
                            end else begin
                                // Start the scan at entry zero
                                rd_en   = 1'b1;
                                n_tag   = '0;
                                n_found = 1'b0;
                                n_key   = HANDLE_BITS'(i_cmd.handle);
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            result       = 1'b1;
                            n_count      = '0;
                            n_out_status = (r_count == '0) ? chl_pkg::ST_FULL_EMPTY
                                                           : chl_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Read data belongs to the entry at r_tag
                if (r_found) begin
                    wr_en   = 1'b1;
                    wr_addr = r_tag - AW'(1);
                    wr_data = rd_data;
                end
                if (last) begin
                    result  = 1'b1;
                    n_state = S_IDLE;
                    if (r_found || match) begin
                        n_count      = r_count - CW'(1);
                        n_out_status = chl_pkg::ST_OK;
                    end else begin
                        n_out_status = chl_pkg::ST_NOT_FOUND;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_tag + AW'(1);
                    n_tag   = r_tag + AW'(1);
                    n_found = r_found || match;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (result) begin
            n_out_count = n_count;
        end
        n_out_valid = result || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag        <= n_tag;
        r_found      <= n_found;
        r_key        <= n_key;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_count = chl_pkg::COUNT_W'(r_out_count);
    assign o_is_empty    = (r_out_count == '0);
    assign o_is_full     = (r_out_count == CAP_COUNT);

endmodule

/* src/compacting_handle_list_core.sv */
// ----------------------------------------------------------------------------
// compacting_handle_list_core
// Packed list of up to CAPACITY handles with insert, remove and clear.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries i_kind and i_handle:
// insert appends, remove deletes the first equal entry and closes the gap,
// clear empties the list. Each item gives one result on the output channel
// (o_out_valid / i_out_ready): status, count after the item, empty and full.
// Items pass through a two-deep command queue into the execution stage.
// Insert and clear: the execution stage takes the command from the queue and
// registers the result; a new command is taken only once the result has left.
// Remove: the slot RAM is scanned from entry zero through its single read
// port, one entry per cycle, up to the last entry below the count; the result
// is registered once the last entry is read; until then no command is taken.
// Reset empties the list, the queue and the result register; slot contents
// are not cleared, and only entries below the count are ever read.
// A stalled receiver holds the result; the queue keeps accepting up to two
// further items, then the input channel deasserts ready.
// ----------------------------------------------------------------------------
module compacting_handle_list_core #(
    parameter int CAPACITY    = chl_pkg::DEF_CAPACITY,
    parameter int HANDLE_BITS = chl_pkg::DEF_HANDLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [chl_pkg::KIND_W-1:0]   i_kind,
    input  logic [chl_pkg::HANDLE_W-1:0] i_handle,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [chl_pkg::STATUS_W-1:0] o_status,
    output logic [chl_pkg::COUNT_W-1:0]  o_entry_count,
    output logic                         o_is_empty,
    output logic                         o_is_full
);

    logic          cmd_valid;
    chl_pkg::t_cmd cmd;
    logic          cmd_pop;

    chl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_handle    (i_handle),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    chl_back #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

endmodule
